/* rtl/svpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package svpe_pkg;

    // Default sizes of the integer body and of the state length field
    localparam int INT_BYTES_DEF       = 8;
    localparam int LEN_FIELD_BYTES_DEF = 4;

    // Largest number of script bytes one transaction can produce
    localparam int MAX_RES   = 9;
    localparam int RES_CNT_W = 4;

    // Input operation codes
    localparam logic [2:0] OPC_INT   = 3'd0;
    localparam logic [2:0] OPC_BOOL  = 3'd1;
    localparam logic [2:0] OPC_LEN   = 3'd2;
    localparam logic [2:0] OPC_DATA  = 3'd3;
    localparam logic [2:0] OPC_BEGIN = 3'd4;
    localparam logic [2:0] OPC_END   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SEQ = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    // Script opcodes
    localparam logic [7:0] SC_FALSE     = 8'h00;
    localparam logic [7:0] SC_PUSH1     = 8'h01;
    localparam logic [7:0] SC_PUSHDATA1 = 8'h4c;
    localparam logic [7:0] SC_PUSHDATA2 = 8'h4d;
    localparam logic [7:0] SC_PUSHDATA4 = 8'h4e;
    localparam logic [7:0] SC_1NEGATE   = 8'h4f;
    localparam logic [7:0] SC_SMALL0    = 8'h50;
    localparam logic [7:0] SC_TRUE      = 8'h51;
    localparam logic [7:0] SC_SIGN      = 8'h80;
    localparam logic [7:0] SC_VERSION   = 8'h00;
    localparam logic [31:0] DIRECT_MAX  = 32'd75;

    // One input transaction
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [63:0] int_value;
        logic               flag;
        logic [31:0]        byte_length;
        logic [7:0]         data_byte;
    } t_item;

    // Encoder state carried between transactions
    typedef struct packed {
        logic        blob;
        logic [31:0] count;
        logic [31:0] left;
        logic        deferred;
    } t_state;

    // Bytes produced for one transaction
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [RES_CNT_W-1:0]    cnt;
        logic [1:0]              status;
    } t_enc_res;

endpackage

`default_nettype wire

/* rtl/svpe_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one script value per transaction
interface svpe_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [63:0] int_value;
    logic               flag;
    logic [31:0]        byte_length;
    logic [7:0]         data_byte;

    modport source (
        output valid, operation, int_value, flag, byte_length, data_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, int_value, flag, byte_length, data_byte,
        output ready
    );
endinterface

// Output channel: one script byte per transaction
interface svpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;

    modport source (
        output valid, out_byte, last, status,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last, status,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/svpe_enc.sv */
`timescale 1ns / 1ps
`default_nettype none

// Encodes one registered item against the current state into up to MAX_RES bytes
module svpe_enc import svpe_pkg::*; #(
    parameter int INT_BYTES       = INT_BYTES_DEF,
    parameter int LEN_FIELD_BYTES = LEN_FIELD_BYTES_DEF
) (
    input  t_item    i_item,
    input  t_state   i_state,
    output t_enc_res o_res,
    output t_state   o_state
);

    localparam logic [63:0] MagMax   = (64'd1 << (8 * INT_BYTES - 1)) - 64'd1;
    localparam logic [63:0] LenLimit = (64'd1 << (8 * LEN_FIELD_BYTES - 1)) - 64'd1;

    logic                        neg;
    logic [63:0]                 mag_raw;
    logic [63:0]                 mag;
    logic [RES_CNT_W-1:0]        raw_len;
    logic [RES_CNT_W-1:0]        body_len;
    logic                        top_bit;
    logic [INT_BYTES-1:0][7:0]   body;
    logic [63:0]                 cnt64;
    logic [32:0]                 cnt_sum;

    // Saturated sign-magnitude of the integer
    always_comb begin
        neg     = i_item.int_value[63];
        mag_raw = neg ? (64'd0 - $unsigned(i_item.int_value)) : $unsigned(i_item.int_value);
        mag     = (mag_raw > MagMax) ? MagMax : mag_raw;
    end

    // Minimal little-endian body with sign bit folded in or appended
    always_comb begin
        raw_len = '0;
        top_bit = 1'b0;
        for (int i = 0; i < INT_BYTES; i++) begin
            if (mag[8*i +: 8] != 8'h00) begin
                raw_len = RES_CNT_W'(i + 1);
                top_bit = mag[8*i + 7];
            end
        end
        body_len = raw_len + RES_CNT_W'(top_bit);
        for (int i = 0; i < INT_BYTES; i++) begin
            body[i] = mag[8*i +: 8];
            if (top_bit && RES_CNT_W'(i) == raw_len) begin
                body[i] = neg ? SC_SIGN : 8'h00;
            end
            if (!top_bit && neg && RES_CNT_W'(i + 1) == raw_len) begin
                body[i] = body[i] | SC_SIGN;
            end
        end
    end

    // Item decode and state update
    always_comb begin
        o_res        = '0;
        o_res.status = ST_OK;
        o_state      = i_state;
        cnt64        = {32'd0, i_state.count};
        cnt_sum      = '0;

        if (i_item.operation == OPC_DATA) begin
            if (i_state.left == 32'd0) begin
                o_res.status = ST_SEQ;
            end else begin
                if (i_state.deferred) begin
                    if (i_item.data_byte >= 8'd1 && i_item.data_byte <= 8'd16) begin
                        o_res.bytes[0] = SC_SMALL0 + i_item.data_byte;
                        o_res.cnt      = RES_CNT_W'(1);
                    end else begin
                        o_res.bytes[0] = SC_PUSH1;
                        o_res.bytes[1] = i_item.data_byte;
                        o_res.cnt      = RES_CNT_W'(2);
                    end
                    o_state.deferred = 1'b0;
                end else begin
                    o_res.bytes[0] = i_item.data_byte;
                    o_res.cnt      = RES_CNT_W'(1);
                end
                o_state.left = i_state.left - 32'd1;
            end
        end else if (i_state.left != 32'd0 || i_item.operation > OPC_END) begin
            o_res.status = ST_SEQ;
        end else if (i_item.operation == OPC_INT) begin
            if (mag == 64'd0) begin
                if (i_state.blob) begin
                    o_res.bytes[0] = SC_PUSH1;
                    o_res.bytes[1] = 8'h00;
                    o_res.cnt      = RES_CNT_W'(2);
                end else begin
                    o_res.bytes[0] = SC_FALSE;
                    o_res.cnt      = RES_CNT_W'(1);
                end
            end else if (!i_state.blob && neg && mag == 64'd1) begin
                o_res.bytes[0] = SC_1NEGATE;
                o_res.cnt      = RES_CNT_W'(1);
            end else if (!i_state.blob && !neg && mag <= 64'd16) begin
                o_res.bytes[0] = SC_SMALL0 + mag[7:0];
                o_res.cnt      = RES_CNT_W'(1);
            end else begin
                o_res.bytes[0] = 8'(body_len);
                for (int k = 0; k < INT_BYTES; k++) begin
                    o_res.bytes[k + 1] = body[k];
                end
                o_res.cnt = body_len + RES_CNT_W'(1);
            end
        end else if (i_item.operation == OPC_BOOL) begin
            if (i_state.blob) begin
                o_res.bytes[0] = i_item.flag ? SC_PUSH1 : SC_FALSE;
            end else begin
                o_res.bytes[0] = i_item.flag ? SC_TRUE : SC_FALSE;
            end
            o_res.cnt = RES_CNT_W'(1);
        end else if (i_item.operation == OPC_LEN) begin
            // single-byte string outside a blob waits for its data byte
            if (!i_state.blob && i_item.byte_length == 32'd1) begin
                o_state.deferred = 1'b1;
            end else if (i_item.byte_length == 32'd0) begin
                o_res.bytes[0] = SC_FALSE;
                o_res.cnt      = RES_CNT_W'(1);
            end else if (i_item.byte_length <= DIRECT_MAX) begin
                o_res.bytes[0] = i_item.byte_length[7:0];
                o_res.cnt      = RES_CNT_W'(1);
            end else if (i_item.byte_length[31:8] == 24'd0) begin
                o_res.bytes[0] = SC_PUSHDATA1;
                o_res.bytes[1] = i_item.byte_length[7:0];
                o_res.cnt      = RES_CNT_W'(2);
            end else if (i_item.byte_length[31:16] == 16'd0) begin
                o_res.bytes[0] = SC_PUSHDATA2;
                o_res.bytes[1] = i_item.byte_length[7:0];
                o_res.bytes[2] = i_item.byte_length[15:8];
                o_res.cnt      = RES_CNT_W'(3);
            end else begin
                o_res.bytes[0] = SC_PUSHDATA4;
                o_res.bytes[1] = i_item.byte_length[7:0];
                o_res.bytes[2] = i_item.byte_length[15:8];
                o_res.bytes[3] = i_item.byte_length[23:16];
                o_res.bytes[4] = i_item.byte_length[31:24];
                o_res.cnt      = RES_CNT_W'(5);
            end
            o_state.left = i_item.byte_length;
        end else if (i_item.operation == OPC_BEGIN) begin
            if (i_state.blob) begin
                o_res.status = ST_SEQ;
            end else begin
                o_res.bytes[0] = i_item.flag ? SC_PUSH1 : SC_FALSE;
                o_res.cnt      = RES_CNT_W'(1);
                o_state.blob   = 1'b1;
                o_state.count  = 32'd0;
            end
        end else begin
            if (!i_state.blob) begin
                o_res.status = ST_SEQ;
            end else begin
                if (cnt64 > LenLimit) begin
                    o_res.status = ST_LEN;
                end else begin
                    for (int i = 0; i < LEN_FIELD_BYTES; i++) begin
                        o_res.bytes[i] = cnt64[8*i +: 8];
                    end
                    o_res.bytes[LEN_FIELD_BYTES] = SC_VERSION;
                    o_res.cnt = RES_CNT_W'(LEN_FIELD_BYTES + 1);
                end
                o_state.blob  = 1'b0;
                o_state.count = 32'd0;
            end
        end

        // Errors give a single zero byte; sequence errors leave state alone
        if (o_res.status == ST_SEQ) begin
            o_state = i_state;
        end
        if (o_res.status != ST_OK) begin
            o_res.bytes = '0;
            o_res.cnt   = RES_CNT_W'(1);
        end else if (o_state.blob) begin
            cnt_sum       = {1'b0, o_state.count} + 33'(o_res.cnt);
            o_state.count = cnt_sum[32] ? 32'hffff_ffff : cnt_sum[31:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/script_value_push_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Script value push encoder. Each input transaction (integer, boolean,
// byte-string length, data byte, state begin, state end) is captured in an
// input register, encoded into 0 to 9 script bytes, and loaded into a result
// buffer that streams one byte per output transaction; the last byte of an
// item carries last=1, and an item in error yields a single zero byte with a
// nonzero status. The first byte of an item is presented once it is in the
// result buffer. The input side takes one item per cycle while the output is
// ready, as long as each item yields at most one byte (data bytes, booleans,
// small integers); an item that yields n bytes holds the result buffer until
// its n bytes are taken, so sustained rate is set by the output byte count,
// and a length of one outside a state blob yields nothing.
module script_value_push_encoder import svpe_pkg::*; #(
    parameter int INT_BYTES       = INT_BYTES_DEF,
    parameter int LEN_FIELD_BYTES = LEN_FIELD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svpe_in_if.sink     i_in,
    svpe_out_if.source  o_out
);

    t_item                    r_item;
    logic                     r_in_valid;
    t_state                   r_st;
    logic [MAX_RES-1:0][7:0]  r_res;
    logic [RES_CNT_W-1:0]     r_cnt;
    logic [RES_CNT_W-1:0]     r_idx;
    logic [1:0]               r_status;
    logic                     r_res_valid;

    t_enc_res                 n_res;
    t_state                   n_st;
    logic                     w_out_acc;
    logic                     w_last_beat;
    logic                     w_load;
    logic                     w_in_acc;
    logic                     w_is_last;

    svpe_enc #(
        .INT_BYTES       (INT_BYTES),
        .LEN_FIELD_BYTES (LEN_FIELD_BYTES)
    ) u_enc (
        .i_item  (r_item),
        .i_state (r_st),
        .o_res   (n_res),
        .o_state (n_st)
    );

    // Handshake control
    assign w_is_last   = (r_idx == r_cnt - RES_CNT_W'(1));
    assign w_out_acc   = r_res_valid && o_out.ready;
    assign w_last_beat = w_out_acc && w_is_last;
    assign w_load      = r_in_valid && (!r_res_valid || w_last_beat);
    assign i_in.ready  = !r_in_valid || w_load;
    assign w_in_acc    = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.operation   <= i_in.operation;
            r_item.int_value   <= i_in.int_value;
            r_item.flag        <= i_in.flag;
            r_item.byte_length <= i_in.byte_length;
            r_item.data_byte   <= i_in.data_byte;
        end
    end

    // Encoder state and result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_res_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else if (w_load) begin
            r_st        <= n_st;
            r_res_valid <= (n_res.cnt != '0);
            r_idx       <= '0;
            r_cnt       <= n_res.cnt;
        end else if (w_last_beat) begin
            r_res_valid <= 1'b0;
        end else if (w_out_acc) begin
            r_idx <= r_idx + RES_CNT_W'(1);
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res    <= n_res.bytes;
            r_status <= n_res.status;
        end
    end

    assign o_out.valid    = r_res_valid;
    assign o_out.out_byte = r_res[r_idx];
    assign o_out.last     = w_is_last;
    assign o_out.status   = r_status;

    // Checks
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_cnt != '0) && (r_idx < r_cnt))
        else $error("result buffer index out of range");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_status != ST_OK) |-> (r_cnt == RES_CNT_W'(1)))
        else $error("error status on a multi-byte result");

    a_deferred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.deferred |-> (r_st.left == 32'd1) && !r_st.blob)
        else $error("deferred single byte without a pending one-byte string");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last_beat && !r_in_valid) |=> !r_res_valid)
        else $error("result buffer not released after last byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_out.ready) |=> r_res_valid && $stable(r_idx))
        else $error("stalled result buffer moved");

endmodule

`default_nettype wire
